FILE: sv/tfa_pkg.sv
// thrust and fin allocation: shared widths, register codes, reset values and types
// used by the cells and the top level; depends on nothing
package tfa_pkg;

	localparam int DATA_W    = 32;
	localparam int CFG_IDX_W = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROTOR     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VLIFT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HLIFT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVER     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE = 3'd5;

	// register reset values
	localparam logic [31:0] RST_ROTOR     = 32'd3355;
	localparam logic [30:0] RST_MAX_SPEED = 31'd196608000;
	localparam logic [30:0] RST_LIFT      = 31'd1293516;
	localparam logic [31:0] RST_LEVER     = 32'hFFFF_999A;
	localparam logic [30:0] RST_MAX_ANGLE = 31'd34315;

	// slowest surge speed used for the fin gain, 0.5 in Q16.16
	localparam logic [31:0] HALF_Q16 = 32'd32768;

	// thruster quotient floor(|F| * 2^THR_SHIFT / k), one quotient bit per cell
	localparam int THR_SHIFT = 40;
	localparam int THR_STEPS = 62;
	localparam int THR_RW    = 32;
	// square root of the thruster quotient, one root bit per cell
	localparam int SQ_STEPS  = THR_STEPS / 2;
	localparam int SQ_RW     = SQ_STEPS + 2;
	// fin quotient, one bit per cell, divisor |x| * L * U^2
	localparam int FIN_STEPS = 31;
	localparam int FIN_DW    = 126;
	localparam int FIN_PRE   = 3;
	localparam int FIN_DLY   = THR_STEPS + SQ_STEPS - FIN_STEPS - FIN_PRE;

	typedef struct packed {
		logic [31:0] pmag;
		logic        pneg;
		logic [31:0] ymag;
		logic        yneg;
		logic [31:0] umag;
	} fin_data_t;

	typedef struct packed {
		logic [31:0] fmag;
		logic        sat;
		logic        fneg;
	} thr_side_t;

	typedef struct packed {
		logic [THR_STEPS-1:0] rad;
		logic                 sat;
		logic                 fneg;
	} sq_side_t;

	typedef struct packed {
		logic [FIN_DW-1:0] dvs;
		logic              sat;
		logic              neg;
	} fin_side_t;

	// magnitude of a signed 32-bit word, most negative value gives 2^31
	function automatic logic [31:0] mag32(input logic [31:0] v);
		mag32 = v[31] ? (32'd0 - v) : v;
	endfunction

endpackage

FILE: sv/thrust_fin_allocation.sv
// thrust and fin allocation top level: registers, input stage, cell chains, output register
// thruster path: input register, 62 divide cells, 31 root cells, then the output register
// throughput: one item per cycle; every stage advances together unless the output stalls
// fin branch: delay line, multiplier stages and 31 divide cells, aligned to the thruster chain
// reset: registers take their default values, all stages and the output empty
// depends on tfa_pkg, tfa_div_cell, tfa_sqrt_cell
module thrust_fin_allocation (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [31:0]                    surge_speed,
	input  logic [31:0]                    force_x,
	input  logic [31:0]                    torque_pitch,
	input  logic [31:0]                    torque_yaw,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [31:0]                    thruster_speed,
	output logic [31:0]                    vertical_fin_angle,
	output logic [31:0]                    horizontal_fin_angle,
	output logic                           fault,
	input  logic                           cfg_we,
	input  logic [tfa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tfa_pkg::DATA_W-1:0]     cfg_data
);

	localparam int THR_STEPS = tfa_pkg::THR_STEPS;
	localparam int THR_RW    = tfa_pkg::THR_RW;
	localparam int SQ_STEPS  = tfa_pkg::SQ_STEPS;
	localparam int SQ_RW     = tfa_pkg::SQ_RW;
	localparam int FIN_STEPS = tfa_pkg::FIN_STEPS;
	localparam int FIN_DW    = tfa_pkg::FIN_DW;
	localparam int FIN_DLY   = tfa_pkg::FIN_DLY;
	localparam int THR_SHIFT = tfa_pkg::THR_SHIFT;

	// configuration registers
	logic [31:0] rotor_q;
	logic [30:0] max_speed_q;
	logic [30:0] vlift_q;
	logic [30:0] hlift_q;
	logic [31:0] lever_q;
	logic [30:0] max_angle_q;

	logic        en;
	logic [31:0] xmag;
	logic        xneg;
	logic        fault_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotor_q     <= tfa_pkg::RST_ROTOR;
			max_speed_q <= tfa_pkg::RST_MAX_SPEED;
			vlift_q     <= tfa_pkg::RST_LIFT;
			hlift_q     <= tfa_pkg::RST_LIFT;
			lever_q     <= tfa_pkg::RST_LEVER;
			max_angle_q <= tfa_pkg::RST_MAX_ANGLE;
		end else if (cfg_we) begin
			case (cfg_index)
				tfa_pkg::CFG_ROTOR:     rotor_q     <= cfg_data;
				tfa_pkg::CFG_MAX_SPEED: max_speed_q <= cfg_data[30:0];
				tfa_pkg::CFG_VLIFT:     vlift_q     <= cfg_data[30:0];
				tfa_pkg::CFG_HLIFT:     hlift_q     <= cfg_data[30:0];
				tfa_pkg::CFG_LEVER:     lever_q     <= cfg_data;
				tfa_pkg::CFG_MAX_ANGLE: max_angle_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	assign xmag    = tfa_pkg::mag32(lever_q);
	assign xneg    = lever_q[31];
	assign fault_c = (rotor_q == 32'd0) || (xmag == 32'd0) ||
		(vlift_q == 31'd0) || (hlift_q == 31'd0);

	// whole pipeline moves unless a finished result is held by the sink
	logic out_valid_q;
	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	// input stage
	logic               v_s1;
	logic [31:0]        fmag_s1;
	logic               fneg_s1;
	tfa_pkg::fin_data_t fin_s1;
	logic [31:0]        umag_c;

	assign umag_c = (tfa_pkg::mag32(surge_speed) < tfa_pkg::HALF_Q16) ?
		tfa_pkg::HALF_Q16 : tfa_pkg::mag32(surge_speed);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fmag_s1     <= tfa_pkg::mag32(force_x);
			fneg_s1     <= force_x[31];
			fin_s1.pmag <= tfa_pkg::mag32(torque_pitch);
			fin_s1.pneg <= torque_pitch[31];
			fin_s1.ymag <= tfa_pkg::mag32(torque_yaw);
			fin_s1.yneg <= torque_yaw[31];
			fin_s1.umag <= umag_c;
		end
	end

	// thruster divide chain, quotient bits from the top down
	logic                 thr_vld [0:THR_STEPS];
	logic [THR_RW-1:0]    thr_rem [0:THR_STEPS];
	logic [THR_STEPS-1:0] thr_quo [0:THR_STEPS];
	logic                 thr_bit [0:THR_STEPS-1];
	tfa_pkg::thr_side_t   thr_sd  [0:THR_STEPS];
	logic [31:0]          thr_top;
	logic                 thr_sat;

	// quotient at or past 2^62 saturates to the speed limit
	assign thr_top = fmag_s1 >> (THR_STEPS - THR_SHIFT);
	assign thr_sat = (thr_top >= rotor_q);

	assign thr_vld[0]     = v_s1;
	assign thr_rem[0]     = thr_sat ? '0 : thr_top;
	assign thr_quo[0]     = '0;
	assign thr_sd[0].fmag = fmag_s1;
	assign thr_sd[0].sat  = thr_sat;
	assign thr_sd[0].fneg = fneg_s1;

	for (genvar j = 0; j < THR_STEPS; j++) begin : g_thr
		localparam int BI = THR_STEPS - 1 - j;
		if (BI >= THR_SHIFT) begin : g_bit
			assign thr_bit[j] = thr_sd[j].fmag[BI-THR_SHIFT];
		end else begin : g_zero
			assign thr_bit[j] = 1'b0;
		end
		tfa_div_cell #(
			.DW(THR_RW),
			.QW(THR_STEPS),
			.SW($bits(tfa_pkg::thr_side_t))
		) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(thr_vld[j]), .rem_i(thr_rem[j]), .quo_i(thr_quo[j]),
			.bit_i(thr_bit[j]), .div_i(rotor_q), .side_i(thr_sd[j]),
			.vld_o(thr_vld[j+1]), .rem_o(thr_rem[j+1]), .quo_o(thr_quo[j+1]),
			.side_o(thr_sd[j+1])
		);
	end

	// square root chain over the thruster quotient
	logic                sq_vld  [0:SQ_STEPS];
	logic [SQ_RW-1:0]    sq_rem  [0:SQ_STEPS];
	logic [SQ_STEPS-1:0] sq_root [0:SQ_STEPS];
	tfa_pkg::sq_side_t   sq_sd   [0:SQ_STEPS];

	assign sq_vld[0]     = thr_vld[THR_STEPS];
	assign sq_rem[0]     = '0;
	assign sq_root[0]    = '0;
	assign sq_sd[0].rad  = thr_quo[THR_STEPS];
	assign sq_sd[0].sat  = thr_sd[THR_STEPS].sat;
	assign sq_sd[0].fneg = thr_sd[THR_STEPS].fneg;

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
		localparam int PI = SQ_STEPS - 1 - j;
		tfa_sqrt_cell #(
			.RW(SQ_RW),
			.QW(SQ_STEPS),
			.SW($bits(tfa_pkg::sq_side_t))
		) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(sq_vld[j]), .rem_i(sq_rem[j]), .root_i(sq_root[j]),
			.pair_i(sq_sd[j].rad[2*PI+1:2*PI]), .side_i(sq_sd[j]),
			.vld_o(sq_vld[j+1]), .rem_o(sq_rem[j+1]), .root_o(sq_root[j+1]),
			.side_o(sq_sd[j+1])
		);
	end

	// fin branch delay line, lines the fin result up with the thruster result
	logic               fdv_q [0:FIN_DLY-1];
	tfa_pkg::fin_data_t fd_q  [0:FIN_DLY-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FIN_DLY; i++) begin
				fdv_q[i] <= 1'b0;
			end
		end else if (en) begin
			fdv_q[0] <= v_s1;
			for (int i = 1; i < FIN_DLY; i++) begin
				fdv_q[i] <= fdv_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fd_q[0] <= fin_s1;
			for (int i = 1; i < FIN_DLY; i++) begin
				fd_q[i] <= fd_q[i-1];
			end
		end
	end

	// lever times each lift, and squared surge speed
	logic               v_s61;
	logic [62:0]        av_s61;
	logic [62:0]        ah_s61;
	logic [63:0]        u2_s61;
	tfa_pkg::fin_data_t fin_s61;
	logic [62:0]        av_c;
	logic [62:0]        ah_c;
	logic [63:0]        u2_c;

	assign av_c = 63'(xmag) * 63'(vlift_q);
	assign ah_c = 63'(xmag) * 63'(hlift_q);
	assign u2_c = 64'(fd_q[FIN_DLY-1].umag) * 64'(fd_q[FIN_DLY-1].umag);

	// 64-bit partial products of the two divisors, from 32-bit halves
	logic               v_s62;
	logic [63:0]        ppv_s62 [0:3];
	logic [63:0]        pph_s62 [0:3];
	tfa_pkg::fin_data_t fin_s62;

	// summed divisors
	logic               v_s63;
	logic [FIN_DW-1:0]  dv_s63;
	logic [FIN_DW-1:0]  dh_s63;
	tfa_pkg::fin_data_t fin_s63;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s61 <= 1'b0;
			v_s62 <= 1'b0;
			v_s63 <= 1'b0;
		end else if (en) begin
			v_s61 <= fdv_q[FIN_DLY-1];
			v_s62 <= v_s61;
			v_s63 <= v_s62;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			av_s61     <= av_c;
			ah_s61     <= ah_c;
			u2_s61     <= u2_c;
			fin_s61    <= fd_q[FIN_DLY-1];
			ppv_s62[0] <= 64'(av_s61[31:0]) * 64'(u2_s61[31:0]);
			ppv_s62[1] <= 64'(av_s61[31:0]) * 64'(u2_s61[63:32]);
			ppv_s62[2] <= 64'(av_s61[62:32]) * 64'(u2_s61[31:0]);
			ppv_s62[3] <= 64'(av_s61[62:32]) * 64'(u2_s61[63:32]);
			pph_s62[0] <= 64'(ah_s61[31:0]) * 64'(u2_s61[31:0]);
			pph_s62[1] <= 64'(ah_s61[31:0]) * 64'(u2_s61[63:32]);
			pph_s62[2] <= 64'(ah_s61[62:32]) * 64'(u2_s61[31:0]);
			pph_s62[3] <= 64'(ah_s61[62:32]) * 64'(u2_s61[63:32]);
			fin_s62    <= fin_s61;
			dv_s63     <= FIN_DW'(ppv_s62[0]) + (FIN_DW'(ppv_s62[1]) << 32) +
				(FIN_DW'(ppv_s62[2]) << 32) + (FIN_DW'(ppv_s62[3]) << 64);
			dh_s63     <= FIN_DW'(pph_s62[0]) + (FIN_DW'(pph_s62[1]) << 32) +
				(FIN_DW'(pph_s62[2]) << 32) + (FIN_DW'(pph_s62[3]) << 64);
			fin_s63    <= fin_s62;
		end
	end

	// fin divide chains: torque * 2^64 over the divisor, quotient at or past 2^31 saturates
	logic                 fv_vld [0:FIN_STEPS];
	logic [FIN_DW-1:0]    fv_rem [0:FIN_STEPS];
	logic [FIN_STEPS-1:0] fv_quo [0:FIN_STEPS];
	tfa_pkg::fin_side_t   fv_sd  [0:FIN_STEPS];
	logic                 fh_vld [0:FIN_STEPS];
	logic [FIN_DW-1:0]    fh_rem [0:FIN_STEPS];
	logic [FIN_STEPS-1:0] fh_quo [0:FIN_STEPS];
	tfa_pkg::fin_side_t   fh_sd  [0:FIN_STEPS];
	logic [FIN_DW-1:0]    topv;
	logic [FIN_DW-1:0]    toph;
	logic                 satv;
	logic                 sath;

	assign topv = FIN_DW'({fin_s63.ymag, 33'd0});
	assign toph = FIN_DW'({fin_s63.pmag, 33'd0});
	assign satv = (topv >= dv_s63);
	assign sath = (toph >= dh_s63);

	assign fv_vld[0]    = v_s63;
	assign fv_rem[0]    = satv ? '0 : topv;
	assign fv_quo[0]    = '0;
	assign fv_sd[0].dvs = dv_s63;
	assign fv_sd[0].sat = satv;
	assign fv_sd[0].neg = fin_s63.yneg ^ xneg;
	assign fh_vld[0]    = v_s63;
	assign fh_rem[0]    = sath ? '0 : toph;
	assign fh_quo[0]    = '0;
	assign fh_sd[0].dvs = dh_s63;
	assign fh_sd[0].sat = sath;
	assign fh_sd[0].neg = !(fin_s63.pneg ^ xneg);

	for (genvar j = 0; j < FIN_STEPS; j++) begin : g_fin
		tfa_div_cell #(
			.DW(FIN_DW),
			.QW(FIN_STEPS),
			.SW($bits(tfa_pkg::fin_side_t))
		) u_vcell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(fv_vld[j]), .rem_i(fv_rem[j]), .quo_i(fv_quo[j]),
			.bit_i(1'b0), .div_i(fv_sd[j].dvs), .side_i(fv_sd[j]),
			.vld_o(fv_vld[j+1]), .rem_o(fv_rem[j+1]), .quo_o(fv_quo[j+1]),
			.side_o(fv_sd[j+1])
		);
		tfa_div_cell #(
			.DW(FIN_DW),
			.QW(FIN_STEPS),
			.SW($bits(tfa_pkg::fin_side_t))
		) u_hcell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(fh_vld[j]), .rem_i(fh_rem[j]), .quo_i(fh_quo[j]),
			.bit_i(1'b0), .div_i(fh_sd[j].dvs), .side_i(fh_sd[j]),
			.vld_o(fh_vld[j+1]), .rem_o(fh_rem[j+1]), .quo_o(fh_quo[j+1]),
			.side_o(fh_sd[j+1])
		);
	end

	// limits, signs and the zero divisor case
	logic [30:0] omega_c;
	logic [30:0] vmag_c;
	logic [30:0] hmag_c;
	logic [31:0] thr_c;
	logic [31:0] vfa_c;
	logic [31:0] hfa_c;

	assign omega_c = (sq_sd[SQ_STEPS].sat || (sq_root[SQ_STEPS] > max_speed_q)) ?
		max_speed_q : sq_root[SQ_STEPS];
	assign vmag_c  = (fv_sd[FIN_STEPS].sat || (fv_quo[FIN_STEPS] > max_angle_q)) ?
		max_angle_q : fv_quo[FIN_STEPS];
	assign hmag_c  = (fh_sd[FIN_STEPS].sat || (fh_quo[FIN_STEPS] > max_angle_q)) ?
		max_angle_q : fh_quo[FIN_STEPS];
	assign thr_c   = sq_sd[SQ_STEPS].fneg ? (32'd0 - {1'b0, omega_c}) : {1'b0, omega_c};
	assign vfa_c   = fv_sd[FIN_STEPS].neg ? (32'd0 - {1'b0, vmag_c}) : {1'b0, vmag_c};
	assign hfa_c   = fh_sd[FIN_STEPS].neg ? (32'd0 - {1'b0, hmag_c}) : {1'b0, hmag_c};

	// output register
	logic [31:0] thr_q;
	logic [31:0] vfa_q;
	logic [31:0] hfa_q;
	logic        fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= sq_vld[SQ_STEPS] & fv_vld[FIN_STEPS] & fh_vld[FIN_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			thr_q   <= fault_c ? 32'd0 : thr_c;
			vfa_q   <= fault_c ? 32'd0 : vfa_c;
			hfa_q   <= fault_c ? 32'd0 : hfa_c;
			fault_q <= fault_c;
		end
	end

	assign out_valid            = out_valid_q;
	assign thruster_speed       = thr_q;
	assign vertical_fin_angle   = vfa_q;
	assign horizontal_fin_angle = hfa_q;
	assign fault                = fault_q;

	// thruster and fin chains stay in step
	a_align: assert property (@(posedge clk) disable iff (!arst_n)
		(sq_vld[SQ_STEPS] == fv_vld[FIN_STEPS]) && (fv_vld[FIN_STEPS] == fh_vld[FIN_STEPS]))
		else $error("thruster and fin chains out of step");

	// a fault result carries all actuator fields at zero
	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && fault) |->
		(thruster_speed == 32'd0) && (vertical_fin_angle == 32'd0) &&
		(horizontal_fin_angle == 32'd0))
		else $error("fault result with nonzero actuator command");

	// fin angles stay within the angle limit
	a_vlim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
		($signed(vertical_fin_angle) <= $signed({1'b0, max_angle_q})) &&
		($signed(vertical_fin_angle) >= -$signed({1'b0, max_angle_q})) &&
		($signed(horizontal_fin_angle) <= $signed({1'b0, max_angle_q})) &&
		($signed(horizontal_fin_angle) >= -$signed({1'b0, max_angle_q})))
		else $error("fin angle beyond limit");

endmodule

FILE: sv/tfa_div_cell.sv
// one restoring division step: shift in a dividend bit, subtract the divisor if it fits
// depends on tfa_pkg for parameter defaults
module tfa_div_cell #(
	parameter int DW = tfa_pkg::THR_RW,
	parameter int QW = tfa_pkg::THR_STEPS,
	parameter int SW = $bits(tfa_pkg::thr_side_t)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  logic [DW-1:0] rem_i,
	input  logic [QW-1:0] quo_i,
	input  logic          bit_i,
	input  logic [DW-1:0] div_i,
	input  logic [SW-1:0] side_i,
	output logic          vld_o,
	output logic [DW-1:0] rem_o,
	output logic [QW-1:0] quo_o,
	output logic [SW-1:0] side_o
);

	logic          vld_q;
	logic [DW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [SW-1:0] side_q;
	logic [DW:0]   r2;
	logic [DW:0]   dx;
	logic [DW:0]   df;
	logic          ge;

	// trial subtraction
	assign r2 = {rem_i, bit_i};
	assign dx = {1'b0, div_i};
	assign df = r2 - dx;
	assign ge = (r2 >= dx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? df[DW-1:0] : r2[DW-1:0];
			quo_q  <= {quo_i[QW-2:0], ge};
			side_q <= side_i;
		end
	end

	assign vld_o  = vld_q;
	assign rem_o  = rem_q;
	assign quo_o  = quo_q;
	assign side_o = side_q;

endmodule

FILE: sv/tfa_sqrt_cell.sv
// one digit step of an integer square root: bring down two radicand bits, try root*4+1
// depends on tfa_pkg for parameter defaults
module tfa_sqrt_cell #(
	parameter int RW = tfa_pkg::SQ_RW,
	parameter int QW = tfa_pkg::SQ_STEPS,
	parameter int SW = $bits(tfa_pkg::sq_side_t)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  logic [RW-1:0] rem_i,
	input  logic [QW-1:0] root_i,
	input  logic [1:0]    pair_i,
	input  logic [SW-1:0] side_i,
	output logic          vld_o,
	output logic [RW-1:0] rem_o,
	output logic [QW-1:0] root_o,
	output logic [SW-1:0] side_o
);

	logic          vld_q;
	logic [RW-1:0] rem_q;
	logic [QW-1:0] root_q;
	logic [SW-1:0] side_q;
	logic [RW+1:0] rem2;
	logic [RW+1:0] trial;
	logic [RW+1:0] df;
	logic          ge;

	// trial subtraction of 4*root+1
	assign rem2  = {rem_i, pair_i};
	assign trial = {{(RW-QW){1'b0}}, root_i, 2'b01};
	assign df    = rem2 - trial;
	assign ge    = (rem2 >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? df[RW-1:0] : rem2[RW-1:0];
			root_q <= {root_i[QW-2:0], ge};
			side_q <= side_i;
		end
	end

	assign vld_o  = vld_q;
	assign rem_o  = rem_q;
	assign root_o = root_q;
	assign side_o = side_q;

endmodule

FILE: tb/tb_thrust_fin_allocation.sv
// testbench for thrust_fin_allocation: directed table then random commands,
// checked against a predictor of thruster speed and fin angles; depends on tfa_pkg
`timescale 1ns / 100ps

module tb_thrust_fin_allocation;

	localparam int LATENCY   = 95;
	localparam int MAX_CYCLE = 400000;
	// register index with no register behind it
	localparam logic [tfa_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	typedef struct packed {
		logic [31:0] spd;
		logic [31:0] ang_v;
		logic [31:0] ang_h;
		logic        flt;
	} actuator_cmd_t;

	typedef struct {
		logic [31:0] u, f, p, y;
		bit          typed;
		actuator_cmd_t want;
	} cmd_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] surge_speed = '0, force_x = '0, torque_pitch = '0, torque_yaw = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] thruster_speed, vertical_fin_angle, horizontal_fin_angle;
	logic fault;
	logic cfg_we = 1'b0;
	logic [tfa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tfa_pkg::DATA_W-1:0] cfg_data = '0;

	// predictor copy of the registers
	logic [31:0] k_rotor;
	logic [30:0] lim_speed, lift_v, lift_h, lim_angle;
	logic [31:0] lever;

	actuator_cmd_t pending_cmds[$];
	int  errors = 0;
	int  cycle = 0;
	int  out_wait = 0;

	thrust_fin_allocation i_dut (.*);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > MAX_CYCLE) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] abs32(logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] q);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > q) b >>= 2;
		while (b != 0) begin
			if (q >= r + b) begin
				q -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [31:0] fin_angle(logic [31:0] tmag, logic [31:0] xmag,
			logic [30:0] lift, logic [63:0] u2, logic [30:0] lim);
		logic [127:0] num, den, q;
		num = {tmag, 96'd0} >> 32;	// tmag * 2^64
		den = 128'(xmag) * 128'(lift);
		q = num / den;
		q = q / 128'(u2);
		if (q > 128'(lim)) return 32'(lim);
		return q[31:0];
	endfunction

	function automatic actuator_cmd_t allocate(logic [31:0] u, f, p, y);
		actuator_cmd_t c;
		logic [31:0] um, fm, pm, ym, xm;
		logic [63:0] omega, u2, q;
		logic [31:0] dv, dh;
		um = abs32(u); fm = abs32(f); pm = abs32(p); ym = abs32(y); xm = abs32(lever);
		if (k_rotor == 0 || xm == 0 || lift_v == 0 || lift_h == 0) begin
			c = '{32'd0, 32'd0, 32'd0, 1'b1};
			return c;
		end
		q = ({64'd0, fm} << 40) / 128'(k_rotor) > 128'hFFFF_FFFF_FFFF_FFFF ?
			64'hFFFF_FFFF_FFFF_FFFF : 64'((128'(fm) << 40) / 128'(k_rotor));
		if (64'(fm) >= (64'(k_rotor) << 22)) omega = 64'(lim_speed);
		else begin
			omega = int_sqrt(q);
			if (omega > 64'(lim_speed)) omega = 64'(lim_speed);
		end
		if (um < tfa_pkg::HALF_Q16) um = tfa_pkg::HALF_Q16;
		u2 = 64'(um) * 64'(um);
		dv = (ym == 0) ? 32'd0 : fin_angle(ym, xm, lift_v, u2, lim_angle);
		dh = (pm == 0) ? 32'd0 : fin_angle(pm, xm, lift_h, u2, lim_angle);
		c.spd   = f[31] ? 32'd0 - omega[31:0] : omega[31:0];
		c.ang_v = (y[31] != lever[31]) ? 32'd0 - dv : dv;
		c.ang_h = (p[31] == lever[31]) ? 32'd0 - dh : dh;
		c.flt   = 1'b0;
		return c;
	endfunction

	// register write with the predictor copy kept in step
	task automatic write_reg(logic [tfa_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			tfa_pkg::CFG_ROTOR:     k_rotor = val;
			tfa_pkg::CFG_MAX_SPEED: lim_speed = val[30:0];
			tfa_pkg::CFG_VLIFT:     lift_v = val[30:0];
			tfa_pkg::CFG_HLIFT:     lift_h = val[30:0];
			tfa_pkg::CFG_LEVER:     lever = val;
			tfa_pkg::CFG_MAX_ANGLE: lim_angle = val[30:0];
			default: ;
		endcase
	endtask

	// one command transfer; expectation queued at acceptance, valid left high
	// so that a command with no idle cycles follows back to back
	task automatic send_cmd(cmd_row_t r);
		actuator_cmd_t e;
		int n;
		n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		surge_speed <= r.u; force_x <= r.f; torque_pitch <= r.p; torque_yaw <= r.y;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		e = allocate(r.u, r.f, r.p, r.y);
		if (r.typed && e != r.want) begin
			$error("table row disagrees with predictor");
			errors++;
		end
		pending_cmds.push_back(r.typed ? r.want : e);
		@(negedge clk);
	endtask

	// entered at the falling edge that ends the last command
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'(int'($urandom_range(0, 131072)) - 65536);
			3: return $urandom & 32'h000F_FFFF;
			4: return 32'd0 - ($urandom & 32'h00FF_FFFF);
			default: return $urandom;
		endcase
	endfunction

	// output side: after each result transfer, stall for a drawn number of cycles
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_wait > 0) begin
				out_stall <= 1'b1;
				out_wait = out_wait - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		actuator_cmd_t w;
		if (arst_n && out_valid && !out_stall) begin
			out_wait = $urandom_range(0, 10);
			if (pending_cmds.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				w = pending_cmds.pop_front();
				if (thruster_speed !== w.spd) begin
					$error("thruster_speed exp %h got %h", w.spd, thruster_speed); errors++;
				end
				if (vertical_fin_angle !== w.ang_v) begin
					$error("vertical_fin_angle exp %h got %h", w.ang_v, vertical_fin_angle);
					errors++;
				end
				if (horizontal_fin_angle !== w.ang_h) begin
					$error("horizontal_fin_angle exp %h got %h", w.ang_h, horizontal_fin_angle);
					errors++;
				end
				if (fault !== w.flt) begin
					$error("fault exp %b got %b", w.flt, fault); errors++;
				end
			end
		end
	end

	cmd_row_t dir_tab[$];

	task automatic add_row(logic [31:0] u, f, p, y, bit typed = 0,
			actuator_cmd_t want = '{0, 0, 0, 0});
		dir_tab.push_back('{u, f, p, y, typed, want});
	endtask

	task automatic random_phase(int n);
		cmd_row_t r;
		for (int i = 0; i < n; i++) begin
			r = '{rnd_word(), rnd_word(), rnd_word(), rnd_word(), 0, '{0, 0, 0, 0}};
			send_cmd(r);
		end
	endtask

	initial begin
		k_rotor = tfa_pkg::RST_ROTOR; lim_speed = tfa_pkg::RST_MAX_SPEED;
		lift_v = tfa_pkg::RST_LIFT; lift_h = tfa_pkg::RST_LIFT;
		lever = tfa_pkg::RST_LEVER; lim_angle = tfa_pkg::RST_MAX_ANGLE;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: zeros, extremes, slow and reversed speed, most negative words
		add_row(0, 0, 0, 0, 1, '{0, 0, 0, 0});
		add_row(32'h0001_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_row(32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001);
		add_row(32'hFFFF_8000, 32'hFFFF_FFFF, 32'h0000_0100, 32'hFFFF_FF00);
		add_row(32'h0000_4000, 32'h0000_0001, 32'h0002_0000, 32'hFFFE_0000);
		add_row(32'hFFFF_FFFF, 32'h0100_0000, 32'h0000_0001, 32'h0000_0000);
		add_row(32'h0010_0000, 32'hFF00_0000, 32'h7FFF_0000, 32'h8000_0001);
		foreach (dir_tab[i]) send_cmd(dir_tab[i]);
		random_phase(300);
		drain();

		// zero lever arm, rotor constant or lift coefficient forces fault
		write_reg(tfa_pkg::CFG_LEVER, 32'd0);
		send_cmd('{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1,
			'{0, 0, 0, 1}});
		drain();
		write_reg(tfa_pkg::CFG_LEVER, 32'h0001_0000);
		write_reg(tfa_pkg::CFG_ROTOR, 32'd0);
		send_cmd('{0, 32'h7FFF_FFFF, 0, 0, 1, '{0, 0, 0, 1}});
		drain();
		write_reg(tfa_pkg::CFG_ROTOR, 32'hFFFF_FFFF);
		write_reg(tfa_pkg::CFG_VLIFT, 32'd0);
		random_phase(10);
		drain();
		write_reg(tfa_pkg::CFG_VLIFT, 32'h7FFF_FFFF);
		write_reg(tfa_pkg::CFG_HLIFT, 32'd0);
		random_phase(10);
		drain();

		// extreme limits
		write_reg(tfa_pkg::CFG_HLIFT, 32'h7FFF_FFFF);
		write_reg(tfa_pkg::CFG_MAX_SPEED, 32'h7FFF_FFFF);
		write_reg(tfa_pkg::CFG_MAX_ANGLE, 32'h7FFF_FFFF);
		write_reg(tfa_pkg::CFG_LEVER, 32'h8000_0000);
		write_reg(CFG_UNUSED, 32'h1234_5678);
		random_phase(250);
		drain();

		write_reg(tfa_pkg::CFG_ROTOR, 32'd1);
		write_reg(tfa_pkg::CFG_MAX_SPEED, 32'd0);
		write_reg(tfa_pkg::CFG_MAX_ANGLE, 32'd0);
		write_reg(tfa_pkg::CFG_VLIFT, 32'd1);
		write_reg(tfa_pkg::CFG_HLIFT, 32'd1);
		write_reg(tfa_pkg::CFG_LEVER, 32'h0000_0001);
		random_phase(200);
		drain();

		write_reg(tfa_pkg::CFG_ROTOR, tfa_pkg::RST_ROTOR);
		write_reg(tfa_pkg::CFG_MAX_SPEED, 32'(tfa_pkg::RST_MAX_SPEED));
		write_reg(tfa_pkg::CFG_VLIFT, 32'd65536);
		write_reg(tfa_pkg::CFG_HLIFT, 32'd200000);
		write_reg(tfa_pkg::CFG_LEVER, 32'h7FFF_FFFF);
		write_reg(tfa_pkg::CFG_MAX_ANGLE, 32'(tfa_pkg::RST_MAX_ANGLE));
		random_phase(330);
		drain();

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
